/* hw/rtl/vna_pkg.sv */
package vna_pkg;

   // Element and accumulator widths follow the request and response formats.
   localparam int ELEM_WIDTH  = 16;
   localparam int MAG_WIDTH   = ELEM_WIDTH + 1;
   localparam int SQ_WIDTH    = 2 * MAG_WIDTH;
   localparam int ACC_WIDTH   = 44;

   // Decoupling queue between the front and back sections.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   // Control and status register map.
   localparam int CSR_ADDR_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_ADDR_NORM_KIND = 2'd0;

   localparam logic [ACC_WIDTH-1:0] ACC_MAX = {ACC_WIDTH{1'b1}};

   typedef enum logic [1:0] {
      KIND_ABS_SUM    = 2'd0,
      KIND_SQUARE_SUM = 2'd1,
      KIND_MAX_ABS    = 2'd2,
      KIND_MAX_GROUP  = 2'd3
   } norm_kind_type;

   // One classified element as it travels from the front to the back.
   typedef struct packed {
      logic [MAG_WIDTH-1:0] mag;
      logic [SQ_WIDTH-1:0]  square;
      logic                 group_end;
      logic                 last;
   } item_type;

endpackage

/* hw/rtl/vector_norm_accumulator.sv */
// Streaming norm and distance engine. Each request carries one element of
// vector A and one of vector B, each with a presence flag; an absent element
// counts as zero, so unequal lengths and single-vector norms need nothing
// special. The norm_kind register selects the sum of absolute differences,
// the sum of squared differences, the largest absolute difference, or the
// largest per-group sum of absolute differences (row or column maximum norm).
// A request with tlast set closes the run: one response carries the 44-bit
// norm and a saturation flag, and the accumulators clear. The block takes one
// request per clock cycle while the queue has room. The front section forms the
// difference, its magnitude and its square in the accept cycle and writes the
// result into a four-entry queue; the back section retires one queue entry per
// cycle unless a closing entry must wait for the response, through a single
// 44-bit saturating adder and two comparators into the response register. A
// response that is not taken holds the back section only when the next closing
// request reaches it; the queue absorbs up to four requests meanwhile. Write
// norm_kind only while no request waits in the queue. A change inside an open
// run keeps the accumulators, and the new kind applies to later requests.
module vector_norm_accumulator (
   input  logic        clock,
   input  logic        reset,

   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] elem_a, [31:16] elem_b
   input  logic [2:0]  req_tuser,   // [0] has_a, [1] has_b, [2] group_end
   input  logic        req_tlast,   // last element of the vector or matrix

   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [43:0] norm_value, [47:44] zero
   output logic [0:0]  rsp_tuser,   // [0] saturated

   // Register port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [vna_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [vna_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [vna_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic        csr_pready
);
   import vna_pkg::*;

   norm_kind_type  kind_ff;
   norm_kind_type  kind_in;
   logic           csr_write;
   item_type       front_item;
   item_type       head_item;
   logic           queue_not_full;
   logic           queue_head_valid;
   logic           queue_pop;
   logic [ACC_WIDTH-1:0] rsp_norm;
   logic           rsp_saturated;

   // The register port never waits; norm_kind reads return the selected kind.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      kind_in = kind_ff;
      if (csr_write && (csr_paddr == CSR_ADDR_NORM_KIND)) begin
         kind_in = norm_kind_type'(csr_pwdata[1:0]);
      end
      csr_prdata = '0;
      if (csr_paddr == CSR_ADDR_NORM_KIND) begin
         csr_prdata = CSR_DATA_WIDTH'(kind_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_ABS_SUM;
      end else begin
         kind_ff <= kind_in;
      end
   end

   // Front: classify and prepare the element pair.
   vna_front u_front (
      .elem_a    (req_tdata[15:0]),
      .elem_b    (req_tdata[31:16]),
      .has_a     (req_tuser[0]),
      .has_b     (req_tuser[1]),
      .group_end (req_tuser[2]),
      .last      (req_tlast),
      .item      (front_item)
   );

   assign req_tready = queue_not_full;

   vna_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_tvalid),
      .push_item  (front_item),
      .not_full   (queue_not_full),
      .pop        (queue_pop),
      .head_valid (queue_head_valid),
      .head_item  (head_item)
   );

   // Back: accumulate and hold the response.
   vna_back u_back (
      .clock         (clock),
      .reset         (reset),
      .kind          (kind_ff),
      .head_item     (head_item),
      .head_valid    (queue_head_valid),
      .head_pop      (queue_pop),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_norm      (rsp_norm),
      .rsp_saturated (rsp_saturated)
   );

   assign rsp_tdata = {4'b0000, rsp_norm};
   assign rsp_tuser = rsp_saturated;

endmodule

/* hw/rtl/vna_front.sv */
module vna_front (
   input  logic [vna_pkg::ELEM_WIDTH-1:0] elem_a,
   input  logic [vna_pkg::ELEM_WIDTH-1:0] elem_b,
   input  logic                           has_a,
   input  logic                           has_b,
   input  logic                           group_end,
   input  logic                           last,
   output vna_pkg::item_type              item
);
   import vna_pkg::*;

   logic signed [MAG_WIDTH-1:0] a_ext;
   logic signed [MAG_WIDTH-1:0] b_ext;
   logic signed [MAG_WIDTH-1:0] diff;
   logic        [MAG_WIDTH-1:0] mag;

   // An absent element counts as zero; the difference is exact in one extra bit.
   always_comb begin
      a_ext = has_a ? MAG_WIDTH'($signed(elem_a)) : '0;
      b_ext = has_b ? MAG_WIDTH'($signed(elem_b)) : '0;
      diff  = a_ext - b_ext;
      mag   = diff[MAG_WIDTH-1] ? MAG_WIDTH'(-diff) : MAG_WIDTH'(diff);
      item.mag       = mag;
      item.square    = SQ_WIDTH'(mag) * SQ_WIDTH'(mag);
      item.group_end = group_end;
      item.last      = last;
   end

endmodule

/* hw/rtl/vna_queue.sv */
module vna_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  vna_pkg::item_type      push_item,
   output logic                   not_full,
   input  logic                   pop,
   output logic                   head_valid,
   output vna_pkg::item_type      head_item
);
   import vna_pkg::*;

   item_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff;
   logic [QPTR_WIDTH-1:0]   wr_ptr_in;
   logic [QPTR_WIDTH-1:0]   rd_ptr_ff;
   logic [QPTR_WIDTH-1:0]   rd_ptr_in;
   logic [QCNT_WIDTH-1:0]   count_ff;
   logic [QCNT_WIDTH-1:0]   count_in;
   logic                    do_push;
   logic                    do_pop;

   always_comb begin
      not_full   = (count_ff != QCNT_WIDTH'(QUEUE_DEPTH));
      head_valid = (count_ff != '0);
      head_item  = entry_ff[rd_ptr_ff];
      do_push    = push && not_full;
      do_pop     = pop && head_valid;
      wr_ptr_in  = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff + QCNT_WIDTH'(do_push) - QCNT_WIDTH'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* hw/rtl/vna_back.sv */
module vna_back (
   input  logic                          clock,
   input  logic                          reset,
   input  vna_pkg::norm_kind_type        kind,
   input  vna_pkg::item_type             head_item,
   input  logic                          head_valid,
   output logic                          head_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [vna_pkg::ACC_WIDTH-1:0] rsp_norm,
   output logic                          rsp_saturated
);
   import vna_pkg::*;

   logic [ACC_WIDTH-1:0] running_ff;
   logic [ACC_WIDTH-1:0] running_in;
   logic [ACC_WIDTH-1:0] group_ff;
   logic [ACC_WIDTH-1:0] group_in;
   logic                 clip_ff;
   logic                 clip_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [ACC_WIDTH-1:0] rsp_norm_ff;
   logic                 rsp_sat_ff;
   logic [ACC_WIDTH-1:0] mag_ext;
   logic [ACC_WIDTH-1:0] addend;
   logic [ACC_WIDTH-1:0] base;
   logic [ACC_WIDTH:0]   sum;
   logic [ACC_WIDTH-1:0] sat_sum;
   logic                 carry;
   logic                 pop;

   // One saturating adder serves the sums of the absolute, square and group kinds.
   always_comb begin
      mag_ext = ACC_WIDTH'(head_item.mag);
      addend  = (kind == KIND_SQUARE_SUM) ? ACC_WIDTH'(head_item.square) : mag_ext;
      base    = (kind == KIND_MAX_GROUP) ? group_ff : running_ff;
      sum     = {1'b0, base} + {1'b0, addend};
      carry   = sum[ACC_WIDTH];
      sat_sum = carry ? ACC_MAX : sum[ACC_WIDTH-1:0];

      running_in = running_ff;
      group_in   = group_ff;
      clip_in    = clip_ff;
      unique case (kind)
         KIND_ABS_SUM, KIND_SQUARE_SUM: begin
            running_in = sat_sum;
            clip_in    = clip_ff | carry;
         end
         KIND_MAX_ABS: begin
            if (mag_ext > running_ff) begin
               running_in = mag_ext;
            end
         end
         KIND_MAX_GROUP: begin
            clip_in = clip_ff | carry;
            if (head_item.group_end || head_item.last) begin
               if (sat_sum > running_ff) begin
                  running_in = sat_sum;
               end
               group_in = '0;
            end else begin
               group_in = sat_sum;
            end
         end
         default: begin
            running_in = running_ff;
         end
      endcase

      // A closing element needs the response register free or draining.
      pop = head_valid && (!head_item.last || !rsp_valid_ff || rsp_ready);
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || (pop && head_item.last);
   end

   assign head_pop      = pop;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_norm      = rsp_norm_ff;
   assign rsp_saturated = rsp_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= '0;
         group_ff     <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            if (head_item.last) begin
               running_ff <= '0;
               group_ff   <= '0;
               clip_ff    <= 1'b0;
            end else begin
               running_ff <= running_in;
               group_ff   <= group_in;
               clip_ff    <= clip_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head_item.last) begin
         rsp_norm_ff <= running_in;
         rsp_sat_ff  <= clip_in;
      end
   end

endmodule

/* hw/rtl/vna_checker.sv */
module vna_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [0:0]  rsp_tuser,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [1:0]  csr_paddr,
   input logic [31:0] csr_pwdata,
   input logic [31:0] csr_prdata
);

   // A response that is not taken stays offered with the same contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response dropped or changed while stalled");

   // Reset leaves no response pending and the request side open.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

   // The padding above the norm is always zero.
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[47:44] == 4'b0000))
      else $error("response padding not zero");

   // A written kind reads back in the next cycle.
   a_kind_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && (csr_paddr == 2'd0)
      |=> (csr_paddr != 2'd0) || (csr_prdata[1:0] == $past(csr_pwdata[1:0])))
      else $error("norm kind readback mismatch");

endmodule

bind vector_norm_accumulator vna_checker u_vna_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tready  (req_tready),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata),
   .rsp_tuser   (rsp_tuser),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata)
);
